// ----- src/gtf_pkg.sv -----
// ----------------------------------------------------------------------------
// gtf_pkg
// Shared types, constants and helpers for the g-h tracking filter.
// ----------------------------------------------------------------------------
package gtf_pkg;

  localparam int DATA_W     = 32;
  localparam int STEP_W     = 16;
  localparam int GAIN_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int STEP_FRAC  = 8;
  localparam int PGAIN_FRAC = 16;
  localparam int RGAIN_FRAC = 12;

  // residual is one bit wider than data; gains enter the multiplier zero-extended
  localparam int RESID_W = DATA_W + 1;
  localparam int MUL_B_W = GAIN_W + 1;
  localparam int PROD_W  = RESID_W + MUL_B_W;
  localparam int SUM_W   = DATA_W + 10;

  localparam logic [CFG_IDX_W-1:0] REG_INIT_POS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_RATE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POS_GAIN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_GAIN  = 3'd4;

  localparam logic [STEP_W-1:0] TIME_STEP_RST = 16'd256;
  localparam logic [GAIN_W-1:0] POS_GAIN_RST  = 16'd19661;
  localparam logic [GAIN_W-1:0] RATE_GAIN_RST = 16'd410;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_STEP,
    S_PRED,
    S_RESID,
    S_MUL_PG,
    S_EST,
    S_COMMIT
  } state_t;

  typedef enum logic [1:0] {
    MUL_RATE_STEP,
    MUL_RESID_PG,
    MUL_RESID_RG
  } mul_sel_t;

  typedef struct packed {
    logic     load_z;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     pred_en;
    logic     resid_en;
    logic     est_en;
    logic     commit;
  } dp_cmd_t;

  function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [SUM_W-1:0] x);
    logic hi_same;
    hi_same = (x[SUM_W-1:DATA_W-1] == {(SUM_W-DATA_W+1){1'b0}}) ||
              (x[SUM_W-1:DATA_W-1] == {(SUM_W-DATA_W+1){1'b1}});
    if (hi_same) begin
      return x[DATA_W-1:0];
    end else if (x[SUM_W-1]) begin
      return {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      return {1'b0, {(DATA_W-1){1'b1}}};
    end
  endfunction

endpackage

// ----- src/gh_tracking_filter_unit.sv -----
// ----------------------------------------------------------------------------
// gh_tracking_filter_unit
// g-h (alpha-beta) tracking filter over signed Q16.16 position samples.
// ----------------------------------------------------------------------------
// Each measurement transaction yields one result holding the updated position
// estimate and the prediction made before the update. The sequencer accepts
// no new measurement until the current one is committed: three dependent
// products (rate * step, residual * g, residual * h/dt) pass one after another
// through a single 33x17 multiplier, with a registered round/saturate add
// between them. A finished result waits in the output register while the next
// measurement is accepted and processed. Writing initial_position or
// initial_rate loads the matching estimate at once. The user must write
// configuration only while the filter is idle; the block does not enforce it.
module gh_tracking_filter_unit
  import gtf_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [DATA_W-1:0]    measurement,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [DATA_W-1:0]    estimate,
  output logic signed [DATA_W-1:0]    prediction,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [DATA_W-1:0]           cfg_data
);

  dp_cmd_t cmd;

  assign cfg_ready = 1'b1;

  gtf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  gtf_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .measurement (measurement),
    .estimate    (estimate),
    .prediction  (prediction)
  );

endmodule

// ----- src/gtf_ctrl.sv -----
// ----------------------------------------------------------------------------
// gtf_ctrl
// Sequencer for the filter update: steps the shared multiplier and the
// update registers, and owns the input and output handshakes.
// ----------------------------------------------------------------------------
module gtf_ctrl
  import gtf_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  output dp_cmd_t cmd
);

  state_t state, state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.mul_sel    = MUL_RATE_STEP;
    in_stall       = (state != S_IDLE);
    out_valid_next = out_valid && out_stall;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_z = 1'b1;
          state_next = S_MUL_STEP;
        end
      end
      S_MUL_STEP: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_RATE_STEP;
        state_next  = S_PRED;
      end
      S_PRED: begin
        cmd.pred_en = 1'b1;
        state_next  = S_RESID;
      end
      S_RESID: begin
        cmd.resid_en = 1'b1;
        state_next   = S_MUL_PG;
      end
      S_MUL_PG: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_RESID_PG;
        state_next  = S_EST;
      end
      S_EST: begin
        cmd.est_en  = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_RESID_RG;
        state_next  = S_COMMIT;
      end
      S_COMMIT: begin
        if (!out_valid || !out_stall) begin
          cmd.commit     = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && in_valid) |=> (state == S_MUL_STEP))
    else $error("accepted transaction did not start the update");

  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("committed result not presented");

  a_hold_when_full: assert property (@(posedge clk) disable iff (rst)
    (state == S_COMMIT && out_valid && out_stall) |=> (state == S_COMMIT))
    else $error("result committed over a waiting transaction");

  a_one_step: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load_z, cmd.pred_en, cmd.resid_en, cmd.est_en, cmd.commit}))
    else $error("more than one update step in a cycle");

endmodule

// ----- src/gtf_datapath.sv -----
// ----------------------------------------------------------------------------
// gtf_datapath
// Estimate state, configuration registers, one shared multiplier and the
// round/saturate adders of the g-h update.
// ----------------------------------------------------------------------------
module gtf_datapath
  import gtf_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  dp_cmd_t                  cmd,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [DATA_W-1:0]        cfg_data,
  input  logic signed [DATA_W-1:0] measurement,
  output logic signed [DATA_W-1:0] estimate,
  output logic signed [DATA_W-1:0] prediction
);

  logic signed [DATA_W-1:0]  position;
  logic signed [DATA_W-1:0]  rate;
  logic [STEP_W-1:0]         time_step;
  logic [GAIN_W-1:0]         position_gain;
  logic [GAIN_W-1:0]         rate_gain;

  logic signed [DATA_W-1:0]  z;
  logic signed [DATA_W-1:0]  pred;
  logic signed [DATA_W-1:0]  est;
  logic signed [RESID_W-1:0] resid;
  logic signed [PROD_W-1:0]  prod;

  logic signed [RESID_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  rnd_step;
  logic signed [PROD_W-1:0]  rnd_pg;
  logic signed [PROD_W-1:0]  rnd_rg;
  logic signed [SUM_W-1:0]   pred_sum;
  logic signed [SUM_W-1:0]   est_sum;
  logic signed [SUM_W-1:0]   rate_sum;

  always_comb begin
    mul_a = RESID_W'(rate);
    mul_b = $signed({1'b0, time_step});
    unique case (cmd.mul_sel)
      MUL_RATE_STEP: begin
        mul_a = RESID_W'(rate);
        mul_b = $signed({1'b0, time_step});
      end
      MUL_RESID_PG: begin
        mul_a = resid;
        mul_b = $signed({1'b0, position_gain});
      end
      MUL_RESID_RG: begin
        mul_a = resid;
        mul_b = $signed({1'b0, rate_gain});
      end
      default: begin
        mul_a = resid;
        mul_b = '0;
      end
    endcase
  end

  assign rnd_step = (prod + $signed(PROD_W'(1) << (STEP_FRAC - 1))) >>> STEP_FRAC;
  assign rnd_pg   = (prod + $signed(PROD_W'(1) << (PGAIN_FRAC - 1))) >>> PGAIN_FRAC;
  assign rnd_rg   = (prod + $signed(PROD_W'(1) << (RGAIN_FRAC - 1))) >>> RGAIN_FRAC;

  assign pred_sum = SUM_W'(position) + $signed(rnd_step[SUM_W-1:0]);
  assign est_sum  = SUM_W'(pred) + $signed(rnd_pg[SUM_W-1:0]);
  assign rate_sum = SUM_W'(rate) + $signed(rnd_rg[SUM_W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      position      <= '0;
      rate          <= '0;
      time_step     <= TIME_STEP_RST;
      position_gain <= POS_GAIN_RST;
      rate_gain     <= RATE_GAIN_RST;
    end else if (cmd.commit) begin
      position <= est;
      rate     <= sat_data(rate_sum);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_INIT_POS:  position      <= $signed(cfg_data);
        REG_INIT_RATE: rate          <= $signed(cfg_data);
        REG_TIME_STEP: time_step     <= cfg_data[STEP_W-1:0];
        REG_POS_GAIN:  position_gain <= cfg_data[GAIN_W-1:0];
        REG_RATE_GAIN: rate_gain     <= cfg_data[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_z) begin
      z <= measurement;
    end
    if (cmd.mul_en) begin
      prod <= mul_a * mul_b;
    end
    if (cmd.pred_en) begin
      pred <= sat_data(pred_sum);
    end
    if (cmd.resid_en) begin
      resid <= RESID_W'(z) - RESID_W'(pred);
    end
    if (cmd.est_en) begin
      est <= sat_data(est_sum);
    end
    if (cmd.commit) begin
      estimate   <= est;
      prediction <= pred;
    end
  end

endmodule

// ----- dv/gh_tracking_filter_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gh_tracking_filter_unit_tb
// Self-checking bench for the g-h tracking filter. A directed table of
// register writes and measurements covers reset values, saturation at both
// rails, zero gains, zero step, ignored register indexes and wide writes to
// narrow registers. Random phases then load fresh register settings and feed
// noisy track samples mixed with raw and extreme values, with random input
// gaps and output stalls in all phases but one. Each result is checked
// against a local fixed-point filter model or the values in its table row.
// ----------------------------------------------------------------------------
module gh_tracking_filter_unit_tb;
  import gtf_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 1500;
  localparam int PHASES       = 8;
  localparam int ROWS         = 31;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_C = 3'd7;

  localparam logic [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [GAIN_W-1:0] GAIN_MAX = '1;
  localparam logic [STEP_W-1:0] STEP_MAX = '1;

  typedef enum logic {ROW_MEAS, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] index;
    logic [DATA_W-1:0]    value;
    logic                 known;
    logic [DATA_W-1:0]    est;
    logic [DATA_W-1:0]    pred;
  } stim_row_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] est;
    logic signed [DATA_W-1:0] pred;
  } track_out_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic signed [DATA_W-1:0] measurement = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] estimate;
  logic signed [DATA_W-1:0] prediction;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [DATA_W-1:0]        cfg_data = '0;

  gh_tracking_filter_unit dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .measurement (measurement),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .estimate    (estimate),
    .prediction  (prediction),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // filter model state
  longint            trk_pos = 0;
  longint            trk_rate = 0;
  logic [STEP_W-1:0] trk_step = TIME_STEP_RST;
  logic [GAIN_W-1:0] trk_pgain = POS_GAIN_RST;
  logic [GAIN_W-1:0] trk_rgain = RATE_GAIN_RST;

  track_out_t pending_q[$];
  track_out_t head;
  int         idle_pct = 38;
  int         stall_pct = 38;
  int         errors = 0;
  int         checked = 0;
  int         sent = 0;
  int         cfg_writes = 0;
  int         cycle_count = 0;

  stim_row_t dir_rows [ROWS] = '{
    '{ROW_MEAS, '0,            32'h0000_0000, 1'b1, 32'h0000_0000, 32'h0000_0000},
    '{ROW_CFG,  REG_POS_GAIN,  32'h0000_0000, 1'b0, '0, '0},
    '{ROW_CFG,  REG_RATE_GAIN, 32'h0000_0000, 1'b0, '0, '0},
    '{ROW_CFG,  REG_TIME_STEP, 32'h0000_0000, 1'b0, '0, '0},
    '{ROW_CFG,  REG_INIT_RATE, DATA_MAX,      1'b0, '0, '0},
    '{ROW_MEAS, '0,            DATA_MAX,      1'b1, 32'h0000_0000, 32'h0000_0000},
    '{ROW_CFG,  REG_INIT_POS,  DATA_MAX,      1'b0, '0, '0},
    '{ROW_CFG,  REG_TIME_STEP, 32'h0000_FFFF, 1'b0, '0, '0},
    '{ROW_MEAS, '0,            DATA_MIN,      1'b1, DATA_MAX, DATA_MAX},
    '{ROW_CFG,  REG_POS_GAIN,  32'h0000_FFFF, 1'b0, '0, '0},
    '{ROW_CFG,  REG_RATE_GAIN, 32'h0000_FFFF, 1'b0, '0, '0},
    '{ROW_MEAS, '0,            DATA_MIN,      1'b0, '0, '0},
    '{ROW_MEAS, '0,            DATA_MIN,      1'b0, '0, '0},
    '{ROW_CFG,  REG_INIT_POS,  DATA_MIN,      1'b0, '0, '0},
    '{ROW_CFG,  REG_INIT_RATE, DATA_MIN,      1'b0, '0, '0},
    '{ROW_CFG,  REG_POS_GAIN,  32'hFFFF_0000, 1'b0, '0, '0},
    '{ROW_MEAS, '0,            DATA_MAX,      1'b1, DATA_MIN, DATA_MIN},
    '{ROW_CFG,  REG_SPARE_A,   32'h1234_5678, 1'b0, '0, '0},
    '{ROW_CFG,  REG_SPARE_B,   32'h7FFF_0001, 1'b0, '0, '0},
    '{ROW_CFG,  REG_SPARE_C,   32'hFFFF_FFFF, 1'b0, '0, '0},
    '{ROW_CFG,  REG_TIME_STEP, 32'hABCD_0100, 1'b0, '0, '0},
    '{ROW_CFG,  REG_POS_GAIN,  32'h0000_4CCD, 1'b0, '0, '0},
    '{ROW_CFG,  REG_RATE_GAIN, 32'hFFFF_019A, 1'b0, '0, '0},
    '{ROW_CFG,  REG_INIT_POS,  32'h0001_0000, 1'b0, '0, '0},
    '{ROW_CFG,  REG_INIT_RATE, 32'h0000_8000, 1'b0, '0, '0},
    '{ROW_MEAS, '0,            32'h0001_8000, 1'b0, '0, '0},
    '{ROW_MEAS, '0,            32'hFFFF_0000, 1'b0, '0, '0},
    '{ROW_MEAS, '0,            32'h5555_5555, 1'b0, '0, '0},
    '{ROW_MEAS, '0,            32'hAAAA_AAAA, 1'b0, '0, '0},
    '{ROW_MEAS, '0,            32'h0000_0001, 1'b0, '0, '0},
    '{ROW_MEAS, '0,            32'hFFFF_FFFF, 1'b0, '0, '0}
  };

  function automatic longint clamp_data(input longint x);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (DATA_W - 1)) - 1;
    lo = -hi - 1;
    if (x > hi) return hi;
    if (x < lo) return lo;
    return x;
  endfunction

  // round to nearest, ties up
  function automatic longint round_shift(input longint x, input int s);
    return (x + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic track_out_t filter_step(input logic signed [DATA_W-1:0] z);
    longint     pred;
    longint     resid;
    longint     est;
    track_out_t r;
    pred  = clamp_data(trk_pos + round_shift(trk_rate * longint'(trk_step), STEP_FRAC));
    resid = longint'(z) - pred;
    est   = clamp_data(pred + round_shift(resid * longint'(trk_pgain), PGAIN_FRAC));
    trk_rate = clamp_data(trk_rate + round_shift(resid * longint'(trk_rgain), RGAIN_FRAC));
    trk_pos  = est;
    r.est  = est[DATA_W-1:0];
    r.pred = pred[DATA_W-1:0];
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] edge_word();
    case ($urandom_range(0, 3))
      0: return DATA_MAX;
      1: return DATA_MIN;
      2: return '0;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] edge_half();
    case ($urandom_range(0, 3))
      0: return {16'($urandom_range(0, 65535)), GAIN_MAX};
      1: return 32'd1;
      2: return '0;
      default: return $urandom;
    endcase
  endfunction

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  // cfg_valid is left high so back-to-back writes need no re-raise
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    if (!cfg_valid) wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_INIT_POS:  trk_pos = longint'(signed'(data));
      REG_INIT_RATE: trk_rate = longint'(signed'(data));
      REG_TIME_STEP: trk_step = data[STEP_W-1:0];
      REG_POS_GAIN:  trk_pgain = data[GAIN_W-1:0];
      REG_RATE_GAIN: trk_rgain = data[GAIN_W-1:0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic send_meas(input logic [DATA_W-1:0] z, input logic known,
                           input track_out_t typed);
    track_out_t modeled;
    cfg_valid <= 1'b0;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    measurement <= z;
    do @(posedge clk); while (in_stall);
    modeled = filter_step(z);
    pending_q.insert(pending_q.size(), known ? typed : modeled);
    sent++;
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (!rst && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        $error("result with no measurement pending: estimate %0d prediction %0d",
               estimate, prediction);
        errors++;
      end else begin
        head = pending_q.pop_front();
        checked++;
        if (estimate !== head.est) begin
          $error("estimate: expected %0d, actual %0d", head.est, estimate);
          errors++;
        end
        if (prediction !== head.pred) begin
          $error("prediction: expected %0d, actual %0d", head.pred, prediction);
          errors++;
        end
      end
    end
    out_stall <= ($urandom_range(0, 99) < stall_pct);
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int               per_phase;
    int               mode;
    int               pick;
    longint           tpos;
    longint           tvel;
    longint           zl;
    logic [DATA_W-1:0] z;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        cfg_write(dir_rows[i].index, dir_rows[i].value);
      end else begin
        send_meas(dir_rows[i].value, dir_rows[i].known,
                  track_out_t'{dir_rows[i].est, dir_rows[i].pred});
      end
    end

    per_phase = RANDOM_ITEMS / PHASES;
    for (int ph = 0; ph < PHASES; ph++) begin
      mode      = ph % 4;
      idle_pct  = (ph == 2) ? 0 : 38;
      stall_pct = (ph == 2) ? 0 : 38;
      case (mode)
        0: begin
          cfg_write(REG_INIT_POS, $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000);
          cfg_write(REG_INIT_RATE, $urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000);
          cfg_write(REG_TIME_STEP, $urandom_range(64, 1024));
          cfg_write(REG_POS_GAIN, $urandom_range(1000, 40000));
          cfg_write(REG_RATE_GAIN, $urandom_range(50, 2000));
        end
        1: begin
          cfg_write(REG_INIT_POS, $urandom);
          cfg_write(REG_INIT_RATE, $urandom);
          cfg_write(REG_TIME_STEP, $urandom);
          cfg_write(REG_POS_GAIN, $urandom);
          cfg_write(REG_RATE_GAIN, $urandom);
          cfg_write(CFG_IDX_W'($urandom_range(REG_SPARE_A, REG_SPARE_C)), $urandom);
        end
        2: begin
          cfg_write(REG_INIT_POS, edge_word());
          cfg_write(REG_INIT_RATE, edge_word());
          cfg_write(REG_TIME_STEP, edge_half());
          cfg_write(REG_POS_GAIN, edge_half());
          cfg_write(REG_RATE_GAIN, edge_half());
        end
        default: begin
          cfg_write(REG_INIT_POS, $urandom);
          cfg_write(REG_INIT_RATE, $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000);
          cfg_write(REG_TIME_STEP, $urandom_range(0, STEP_MAX));
          cfg_write(REG_POS_GAIN, $urandom_range(0, 255));
          cfg_write(REG_RATE_GAIN, $urandom_range(0, 255));
        end
      endcase

      // noisy samples along a bouncing straight-line track
      tpos = longint'($urandom_range(0, 32'h1FFF_FFFF)) - 64'sh1000_0000;
      tvel = longint'($urandom_range(0, 32'h0020_0000)) - 64'sh0010_0000;
      for (int n = 0; n < per_phase; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
          zl = clamp_data(tpos + longint'($urandom_range(0, 32'h0008_0000)) - 64'sh4_0000);
          z  = zl[DATA_W-1:0];
        end else if (pick < 90) begin
          z = $urandom;
        end else begin
          z = edge_word();
        end
        send_meas(z, 1'b0, '0);
        tpos += tvel;
        if (tpos > 64'sh4000_0000 || tpos < -64'sh4000_0000) tvel = -tvel;
        if ($urandom_range(0, 199) == 0) wait_drained();
      end
    end

    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d measurements and %0d register writes over %0d setting phases;",
             sent, cfg_writes, PHASES);
    $display("compared %0d results, %0d mismatches.", checked, errors);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/gtf_pkg.sv
src/gtf_ctrl.sv
src/gtf_datapath.sv
src/gh_tracking_filter_unit.sv
dv/gh_tracking_filter_unit_tb.sv
